[sv/bwa_pkg.sv]
`timescale 1ns / 1ps

package bwa_pkg;

  localparam int unsigned CHANNELS    = 64;
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned CH_AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CH_W   = 6;
  localparam int unsigned TOL_W  = 8;
  localparam int unsigned SUM_W  = 48;

  localparam int unsigned DIV_N_W   = SUM_W;
  localparam int unsigned DIV_D_W   = DATA_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_N_W + 1);

  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [DATA_W-1:0] WINDOW_RESET = DATA_W'(1000);
  localparam logic [TOL_W-1:0]  TOL_RESET    = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW = 1'b0,
    REG_TOL    = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_BLOCK = 3'd1,
    ST_MOD   = 3'd2,
    ST_ACC   = 3'd3,
    ST_DIV   = 3'd4,
    ST_OUT   = 3'd5
  } state_e;

  typedef struct packed {
    logic                   en;
    logic [CH_AW-1:0]       addr;
    logic [SUM_W-1:0]       sum;
    logic [COUNT_WIDTH-1:0] cnt;
  } acc_wr_t;

  typedef struct packed {
    logic [SUM_W-1:0]       sum;
    logic [COUNT_WIDTH-1:0] cnt;
  } acc_data_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[sv/bwa_serial_div.sv]
`timescale 1ns / 1ps

module bwa_serial_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [bwa_pkg::DIV_N_W-1:0]      dividend_i,
  input  logic [bwa_pkg::DIV_D_W-1:0]      divisor_i,
  output bwa_pkg::div_stat_t               stat_o,
  output logic [bwa_pkg::DIV_N_W-1:0]      quotient_o,
  output logic [bwa_pkg::DIV_D_W-1:0]      remainder_o
);
  import bwa_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_N_W-1:0]   quo_q, quo_d;
  logic [DIV_D_W-1:0]   rem_q, rem_d;
  logic [DIV_D_W-1:0]   dvs_q, dvs_d;
  logic [DIV_D_W:0]     trial;
  logic [DIV_D_W:0]     diff;
  logic                 qbit;

  // one quotient bit per cycle, restoring
  assign trial = {rem_q, quo_q[DIV_N_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign qbit  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_N_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DIV_N_W-2:0], qbit};
      rem_d = qbit ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

[sv/bwa_acc_store.sv]
`timescale 1ns / 1ps

module bwa_acc_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [bwa_pkg::CH_AW-1:0]   rd_addr_i,
  input  bwa_pkg::acc_wr_t            wr_i,
  output bwa_pkg::acc_data_t          rd_o
);
  import bwa_pkg::*;

  logic [SUM_W-1:0]       sum_mem [CHANNELS];
  logic [COUNT_WIDTH-1:0] cnt_mem [CHANNELS];
  logic [CHANNELS-1:0]    vld_q;
  logic [SUM_W-1:0]       rd_sum_q;
  logic [COUNT_WIDTH-1:0] rd_cnt_q;
  logic                   rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      sum_mem[wr_i.addr] <= wr_i.sum;
      cnt_mem[wr_i.addr] <= wr_i.cnt;
    end
    if (rd_en_i) begin
      rd_sum_q <= sum_mem[rd_addr_i];
      rd_cnt_q <= cnt_mem[rd_addr_i];
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  // entries never written read as zero
  assign rd_o.sum = rd_vld_q ? rd_sum_q : '0;
  assign rd_o.cnt = rd_vld_q ? rd_cnt_q : '0;

endmodule

[sv/block_window_averager_top.sv]
`timescale 1ns / 1ps

// channel  | direction | handshake                    | payload
// ---------+-----------+------------------------------+------------------------------------
// in       | input     | in_valid_i / in_stall_o      | timestamp, elapsed_time, channel,
//          |           |                              | is_instantaneous, sample_value
// out      | output    | out_valid_o / out_stall_i    | out_channel, out_value
// cfg      | input     | cfg_we_i (no wait)           | cfg_index_i, cfg_data_i
//
// One request at a time: accept, lookup, update and, once the window is reached, output
// steps per request, plus the window modulo and the average where needed, both on the one
// shared bit-serial divider (48 steps, then a done strobe).
// Reset clears block state and the accumulator valid bits at once; no clearing pass.
// A result waits in the output register while the next request is taken; a stalled
// output only holds the block at its final step.

module block_window_averager_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [bwa_pkg::DATA_W-1:0]         timestamp_i,
  input  logic [bwa_pkg::DATA_W-1:0]         elapsed_time_i,
  input  logic [bwa_pkg::CH_W-1:0]           channel_i,
  input  logic                               is_instantaneous_i,
  input  logic signed [bwa_pkg::DATA_W-1:0]  sample_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [bwa_pkg::CH_W-1:0]           out_channel_o,
  output logic signed [bwa_pkg::DATA_W-1:0]  out_value_o,
  input  logic                               cfg_we_i,
  input  logic [bwa_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bwa_pkg::DATA_W-1:0]         cfg_data_i
);
  import bwa_pkg::*;

  localparam logic [SUM_W-1:0] SumMax = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SumMin = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [DIV_N_W-1:0] QPosMax = DIV_N_W'({1'b0, {(DATA_W-1){1'b1}}});
  localparam logic [DIV_N_W-1:0] QNegMax = DIV_N_W'({1'b1, {(DATA_W-1){1'b0}}});

  state_e state_q, state_d;

  logic [DATA_W-1:0] ts_q, el_q, val_q;
  logic [CH_W-1:0]   ch_q;
  logic              inst_q;

  logic [DATA_W-1:0] rem_q, last_ts_q, win_q;
  logic [TOL_W-1:0]  tol_q;
  logic              seen_q, reached_q;

  logic              out_valid_q;
  logic [CH_W-1:0]   out_ch_q;
  logic [DATA_W-1:0] out_val_q, res_q;

  logic [DATA_W-1:0]  win_eff, fwd, bwd, tol_ext;
  logic               new_blk, hit, has_acc, out_free, need_avg;
  logic [DATA_W:0]    sum33;
  logic [SUM_W:0]     acc_sum;
  logic [SUM_W-1:0]   acc_sat, sum_mag;
  logic               cnt_full;
  logic [DATA_W-1:0]  avg_sat;

  logic               rd_en, div_start;
  acc_wr_t            acc_wr;
  acc_data_t          acc_rd;
  div_stat_t          div_stat;
  logic [DIV_N_W-1:0] div_dividend, div_quo;
  logic [DIV_D_W-1:0] div_divisor, div_rem;

  assign win_eff  = (win_q == '0) ? DATA_W'(1) : win_q;
  assign fwd      = ts_q - last_ts_q;
  assign bwd      = last_ts_q - ts_q;
  assign tol_ext  = DATA_W'(tol_q);
  assign new_blk  = ($signed(fwd) > $signed(tol_ext)) || ($signed(bwd) > $signed(tol_ext));
  assign sum33    = {1'b0, rem_q} + {1'b0, el_q};
  assign hit      = sum33 >= {1'b0, win_eff};
  assign has_acc  = 32'(ch_q) < CHANNELS;
  assign out_free = !out_valid_q || !out_stall_i;

  assign acc_sum  = {acc_rd.sum[SUM_W-1], acc_rd.sum} +
                    {{(SUM_W+1-DATA_W){val_q[DATA_W-1]}}, val_q};
  assign acc_sat  = (acc_sum[SUM_W] == acc_sum[SUM_W-1]) ? acc_sum[SUM_W-1:0] :
                    (acc_sum[SUM_W] ? SumMin : SumMax);
  assign cnt_full = &acc_rd.cnt;
  assign need_avg = inst_q && has_acc && (acc_rd.cnt != '0);
  assign sum_mag  = acc_rd.sum[SUM_W-1] ? (~acc_rd.sum + SUM_W'(1)) : acc_rd.sum;

  always_comb begin
    if (acc_rd.sum[SUM_W-1]) begin
      avg_sat = (div_quo > QNegMax) ? QNegMax[DATA_W-1:0] : (~div_quo[DATA_W-1:0] + DATA_W'(1));
    end else begin
      avg_sat = (div_quo > QPosMax) ? QPosMax[DATA_W-1:0] : div_quo[DATA_W-1:0];
    end
  end

  assign div_dividend = (state_q == ST_BLOCK) ? DIV_N_W'(sum33) : sum_mag;
  assign div_divisor  = (state_q == ST_BLOCK) ? win_eff : DIV_D_W'(acc_rd.cnt);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_BLOCK;
      end
      ST_BLOCK: begin
        state_d = (seen_q && new_blk && hit) ? ST_MOD : ST_ACC;
      end
      ST_MOD: begin
        if (div_stat.done) state_d = ST_ACC;
      end
      ST_ACC: begin
        if (!reached_q) state_d = ST_IDLE;
        else if (need_avg) state_d = ST_DIV;
        else state_d = ST_OUT;
      end
      ST_DIV: begin
        if (div_stat.done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    rd_en       = (state_q == ST_BLOCK);
    div_start   = 1'b0;
    acc_wr.en   = 1'b0;
    acc_wr.addr = CH_AW'(ch_q);
    acc_wr.sum  = '0;
    acc_wr.cnt  = '0;
    case (state_q)
      ST_BLOCK: begin
        div_start = seen_q && new_blk && hit;
      end
      ST_ACC: begin
        if (reached_q) begin
          div_start = need_avg;
          acc_wr.en = inst_q && has_acc;
        end else begin
          acc_wr.en  = inst_q && has_acc && !cnt_full;
          acc_wr.sum = acc_sat;
          acc_wr.cnt = acc_rd.cnt + COUNT_WIDTH'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rem_q       <= '0;
      last_ts_q   <= '0;
      seen_q      <= 1'b0;
      reached_q   <= 1'b0;
      win_q       <= WINDOW_RESET;
      tol_q       <= TOL_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_WINDOW: win_q <= cfg_data_i;
          REG_TOL:    tol_q <= cfg_data_i[TOL_W-1:0];
          default: ;
        endcase
      end
      if (state_q == ST_BLOCK) begin
        last_ts_q <= ts_q;
        if (!seen_q) begin
          seen_q <= 1'b1;
        end else if (new_blk && !hit) begin
          rem_q     <= sum33[DATA_W-1:0];
          reached_q <= 1'b0;
        end
      end
      if (state_q == ST_MOD && div_stat.done) begin
        rem_q     <= div_rem;
        reached_q <= 1'b1;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      ts_q   <= timestamp_i;
      el_q   <= elapsed_time_i;
      ch_q   <= channel_i;
      inst_q <= is_instantaneous_i;
      val_q  <= sample_value_i;
    end
    if (state_q == ST_ACC) res_q <= val_q;
    if (state_q == ST_DIV && div_stat.done) res_q <= avg_sat;
    if (state_q == ST_OUT && out_free) begin
      out_ch_q  <= ch_q;
      out_val_q <= res_q;
    end
  end

  bwa_acc_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (CH_AW'(ch_q)),
    .wr_i      (acc_wr),
    .rd_o      (acc_rd)
  );

  bwa_serial_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .stat_o      (div_stat),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_ch_q;
  assign out_value_o   = out_val_q;

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_no_rd_wr_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && acc_wr.en))
    else $error("accumulator read and write in one cycle");

  a_reached_from_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(reached_q) |-> $past(state_q) == ST_MOD)
    else $error("window flag set outside modulo step");

  a_rem_below_win: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD && div_stat.done) |=> rem_q < win_eff)
    else $error("remainder not reduced below window");
`endif

endmodule
